FILE: src/fcw_pkg.sv
package fcw_pkg;

  localparam int unsigned TABLE_BYTES = 8192;
  localparam int unsigned TableAw     = $clog2(TABLE_BYTES);
  localparam int unsigned BankDepth   = TABLE_BYTES / 2;
  localparam int unsigned BankAw      = TableAw - 1;

  localparam int unsigned ClusterW = 12;
  localparam int unsigned TabAddrW = 13;
  localparam int unsigned LbaW     = 32;
  localparam int unsigned SpcW     = 8;

  localparam logic [ClusterW-1:0] EntryMask = 12'hFFF;
  localparam logic [ClusterW-1:0] EndMark   = 12'hFF8;

  localparam logic [LbaW-1:0] DataStartReset = 32'd33;
  localparam logic [SpcW-1:0] SpcReset       = 8'd1;

  // Configuration register indexes.
  localparam logic CfgDataStartLba     = 1'b0;
  localparam logic CfgSectorsPerCluster = 1'b1;

  typedef enum logic [1:0] {
    OpLoad    = 2'd0,
    OpStart   = 2'd1,
    OpAdvance = 2'd2
  } opcode_e;

  typedef enum logic {
    StIdle,
    StLook
  } state_e;

  typedef struct packed {
    logic               en;
    logic [TableAw-1:0] addr;
    logic [7:0]         data;
  } table_wr_t;

  typedef struct packed {
    logic               en;
    logic [TableAw-1:0] addr;
  } table_rd_t;

endpackage

FILE: src/fcw_if.sv
interface fcw_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       opcode;
  logic [fcw_pkg::TabAddrW-1:0]     table_address;
  logic [7:0]                       table_byte;
  logic [fcw_pkg::ClusterW-1:0]     first_cluster;

  modport source (output valid, opcode, table_address, table_byte, first_cluster,
                  input ready);
  modport sink (input valid, opcode, table_address, table_byte, first_cluster,
                output ready);
endinterface

interface fcw_out_if;
  logic                         valid;
  logic                         ready;
  logic [fcw_pkg::ClusterW-1:0] cluster;
  logic [fcw_pkg::LbaW-1:0]     sector_address;
  logic [fcw_pkg::ClusterW-1:0] next_cluster;
  logic                         chain_end;
  logic                         no_chain;

  modport source (output valid, cluster, sector_address, next_cluster, chain_end, no_chain,
                  input ready);
  modport sink (input valid, cluster, sector_address, next_cluster, chain_end, no_chain,
                output ready);
endinterface

FILE: src/fcw_table.sv
module fcw_table (
  input  logic               clk_i,
  input  fcw_pkg::table_wr_t wr_i,
  input  fcw_pkg::table_rd_t rd_i,
  output logic [7:0]         lo_byte_o,
  output logic [7:0]         hi_byte_o
);

  // The table is split into even and odd byte banks so that both bytes of
  // an entry come out of one read.
  logic [7:0] even_mem [fcw_pkg::BankDepth];
  logic [7:0] odd_mem  [fcw_pkg::BankDepth];

  logic [7:0] even_rd_q;
  logic [7:0] odd_rd_q;
  logic       at_odd_q;

  logic [fcw_pkg::BankAw-1:0] wr_bank;
  logic [fcw_pkg::BankAw-1:0] rd_bank;
  logic [fcw_pkg::BankAw-1:0] rd_bank_even;

  assign wr_bank      = wr_i.addr[fcw_pkg::TableAw-1:1];
  assign rd_bank      = rd_i.addr[fcw_pkg::TableAw-1:1];
  assign rd_bank_even = rd_i.addr[0] ? fcw_pkg::BankAw'(rd_bank + fcw_pkg::BankAw'(1))
                                     : rd_bank;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      if (wr_i.addr[0]) begin
        odd_mem[wr_bank] <= wr_i.data;
      end else begin
        even_mem[wr_bank] <= wr_i.data;
      end
    end
  end

  // Read data holds until the next read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      even_rd_q <= even_mem[rd_bank_even];
      odd_rd_q  <= odd_mem[rd_bank];
      at_odd_q  <= rd_i.addr[0];
    end
  end

  assign lo_byte_o = at_odd_q ? odd_rd_q : even_rd_q;
  assign hi_byte_o = at_odd_q ? even_rd_q : odd_rd_q;

endmodule

FILE: src/fcw_ctrl.sv
module fcw_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fcw_in_if.sink                        in_req,
  fcw_out_if.source                     out_res,
  input  logic [fcw_pkg::LbaW-1:0]      data_start_lba_i,
  input  logic [fcw_pkg::SpcW-1:0]      sectors_per_cluster_i,
  output fcw_pkg::table_wr_t            table_wr_o,
  output fcw_pkg::table_rd_t            table_rd_o,
  input  logic [7:0]                    lo_byte_i,
  input  logic [7:0]                    hi_byte_i
);

  fcw_pkg::state_e state_q, state_d;

  logic [fcw_pkg::ClusterW-1:0] current_next_q, current_next_d;
  logic                         chain_active_q, chain_active_d;
  logic [fcw_pkg::ClusterW-1:0] cl_q, cl_d;
  logic                         no_chain_q, no_chain_d;
  logic [fcw_pkg::LbaW-1:0]     prod_q, prod_d;

  logic                         out_valid_q, out_valid_d;
  logic [fcw_pkg::ClusterW-1:0] out_cluster_q, out_cluster_d;
  logic [fcw_pkg::LbaW-1:0]     out_sector_q, out_sector_d;
  logic [fcw_pkg::ClusterW-1:0] out_next_q, out_next_d;
  logic                         out_end_q, out_end_d;
  logic                         out_nochain_q, out_nochain_d;

  logic                         accept;
  logic                         slot_free;
  logic                         load_out;
  logic [fcw_pkg::ClusterW-1:0] cl_sel;
  logic [fcw_pkg::TabAddrW-1:0] entry_at;
  logic [fcw_pkg::LbaW-1:0]     cl_minus2;
  logic [15:0]                  word;
  logic [fcw_pkg::ClusterW-1:0] entry;
  logic                         entry_end;

  assign accept    = in_req.valid && in_req.ready;
  assign slot_free = !out_valid_q || out_res.ready;

  assign cl_sel    = (in_req.opcode == fcw_pkg::OpStart) ? in_req.first_cluster
                                                         : current_next_q;
  assign entry_at  = {1'b0, cl_sel} + {2'b00, cl_sel[fcw_pkg::ClusterW-1:1]};
  assign cl_minus2 = fcw_pkg::LbaW'(cl_sel) - fcw_pkg::LbaW'(2);

  assign word      = {hi_byte_i, lo_byte_i};
  assign entry     = cl_q[0] ? word[15:4] : (word[11:0] & fcw_pkg::EntryMask);
  assign entry_end = entry >= fcw_pkg::EndMark;

  always_comb begin
    state_d        = state_q;
    current_next_d = current_next_q;
    chain_active_d = chain_active_q;
    cl_d           = cl_q;
    no_chain_d     = no_chain_q;
    prod_d         = prod_q;
    load_out       = 1'b0;
    in_req.ready   = 1'b0;
    table_wr_o     = '0;
    table_rd_o     = '0;
    out_cluster_d  = out_cluster_q;
    out_sector_d   = out_sector_q;
    out_next_d     = out_next_q;
    out_end_d      = out_end_q;
    out_nochain_d  = out_nochain_q;

    case (state_q)
      fcw_pkg::StIdle: begin
        // Ready is high throughout this state, so valid alone marks a request.
        in_req.ready = 1'b1;
        if (in_req.valid) begin
          case (in_req.opcode)
            fcw_pkg::OpLoad: begin
              table_wr_o.en   = 32'(in_req.table_address) < fcw_pkg::TABLE_BYTES;
              table_wr_o.addr = fcw_pkg::TableAw'(in_req.table_address);
              table_wr_o.data = in_req.table_byte;
            end
            fcw_pkg::OpStart, fcw_pkg::OpAdvance: begin
              table_rd_o.en   = 1'b1;
              table_rd_o.addr = fcw_pkg::TableAw'(entry_at);
              cl_d            = cl_sel;
              no_chain_d      = (in_req.opcode == fcw_pkg::OpAdvance) && !chain_active_q;
              prod_d          = cl_minus2 * fcw_pkg::LbaW'(sectors_per_cluster_i);
              state_d         = fcw_pkg::StLook;
            end
            default: begin
            end
          endcase
        end
      end
      fcw_pkg::StLook: begin
        // The table read data holds, so a stalled result is simply rebuilt.
        if (slot_free) begin
          load_out = 1'b1;
          state_d  = fcw_pkg::StIdle;
          if (no_chain_q) begin
            out_cluster_d = '0;
            out_sector_d  = '0;
            out_next_d    = '0;
            out_end_d     = 1'b0;
            out_nochain_d = 1'b1;
          end else begin
            out_cluster_d  = cl_q;
            out_sector_d   = data_start_lba_i + prod_q;
            out_next_d     = entry;
            out_end_d      = entry_end;
            out_nochain_d  = 1'b0;
            current_next_d = entry;
            chain_active_d = !entry_end;
          end
        end
      end
      default: begin
        state_d = fcw_pkg::StIdle;
      end
    endcase
  end

  assign out_valid_d = (out_valid_q && !out_res.ready) || load_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fcw_pkg::StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      current_next_q <= '0;
      chain_active_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      current_next_q <= current_next_d;
      chain_active_q <= chain_active_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q          <= cl_d;
    no_chain_q    <= no_chain_d;
    prod_q        <= prod_d;
    out_cluster_q <= out_cluster_d;
    out_sector_q  <= out_sector_d;
    out_next_q    <= out_next_d;
    out_end_q     <= out_end_d;
    out_nochain_q <= out_nochain_d;
  end

  assign out_res.valid          = out_valid_q;
  assign out_res.cluster        = out_cluster_q;
  assign out_res.sector_address = out_sector_q;
  assign out_res.next_cluster   = out_next_q;
  assign out_res.chain_end      = out_end_q;
  assign out_res.no_chain       = out_nochain_q;

  a_lookup_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_req.opcode == fcw_pkg::OpStart || in_req.opcode == fcw_pkg::OpAdvance)
    |=> state_q == fcw_pkg::StLook)
    else $error("start or advance request did not enter the lookup");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == fcw_pkg::StLook && !slot_free
    |=> state_q == fcw_pkg::StLook && $stable(cl_q) && $stable(no_chain_q))
    else $error("stalled lookup lost its cluster");

  a_closed_chain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid && (out_res.chain_end || out_res.no_chain) |-> !chain_active_q)
    else $error("chain left active after an end or no-chain result");

  a_no_chain_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_res.valid && out_res.no_chain
    |-> out_res.cluster == '0 && out_res.next_cluster == '0 && !out_res.chain_end
        && out_res.sector_address == '0)
    else $error("no-chain result carries nonzero fields");

endmodule

FILE: src/fat12_cluster_chain_walker.sv
// Load requests give no result.
// Start and advance requests issue the table read in the cycle of acceptance; the result
// is built in the lookup state and registered once the output slot is free.
// A new request is not taken until that result is registered and the walker is idle again.
// Reset clears control state and sets the configuration to its defaults; the table is
// not cleared and holds undefined bytes until loaded.
module fat12_cluster_chain_walker (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  fcw_in_if.sink                   in_req,
  fcw_out_if.source                out_res,
  input  logic                     cfg_we_i,
  input  logic                     cfg_index_i,
  input  logic [fcw_pkg::LbaW-1:0] cfg_wdata_i
);

  logic [fcw_pkg::LbaW-1:0] data_start_lba_q;
  logic [fcw_pkg::SpcW-1:0] sectors_per_cluster_q;

  fcw_pkg::table_wr_t table_wr;
  fcw_pkg::table_rd_t table_rd;
  logic [7:0]         lo_byte;
  logic [7:0]         hi_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_start_lba_q      <= fcw_pkg::DataStartReset;
      sectors_per_cluster_q <= fcw_pkg::SpcReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        fcw_pkg::CfgDataStartLba:      data_start_lba_q      <= cfg_wdata_i;
        fcw_pkg::CfgSectorsPerCluster: sectors_per_cluster_q <= cfg_wdata_i[fcw_pkg::SpcW-1:0];
        default: begin
        end
      endcase
    end
  end

  fcw_table u_table (
    .clk_i     (clk_i),
    .wr_i      (table_wr),
    .rd_i      (table_rd),
    .lo_byte_o (lo_byte),
    .hi_byte_o (hi_byte)
  );

  fcw_ctrl u_ctrl (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_req                (in_req),
    .out_res               (out_res),
    .data_start_lba_i      (data_start_lba_q),
    .sectors_per_cluster_i (sectors_per_cluster_q),
    .table_wr_o            (table_wr),
    .table_rd_o            (table_rd),
    .lo_byte_i             (lo_byte),
    .hi_byte_i             (hi_byte)
  );

endmodule
